[design/spc_pkg.sv]
// shared types, constants and helpers for the sprite pixel collision block
package spc_pkg;

  localparam int FRAME_W_MAX = 64;
  localparam int FRAME_H_MAX = 64;
  localparam int FRAMES_MAX  = 4;

  localparam int SHEET_W = FRAME_W_MAX * FRAMES_MAX;
  localparam int SHEET_H = FRAME_H_MAX;

  localparam int COL_W    = $clog2(SHEET_W);
  localparam int ROW_W    = $clog2(SHEET_H);
  localparam int OFFX_W   = $clog2(FRAME_W_MAX);
  localparam int FRM_W    = 2;
  localparam int SHIFT_W  = $clog2((1 << FRM_W) * FRAME_W_MAX);
  localparam int DIM_W    = 7;
  localparam int KEY_W    = 32;
  localparam int POS_W    = 12;
  localparam int CRD_W    = POS_W + 1;
  localparam int SX_W     = 8;
  localparam int SY_W     = 6;
  localparam int OP_W     = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [DIM_W-1:0] FW_MAX_V = DIM_W'(FRAME_W_MAX);
  localparam logic [DIM_W-1:0] FH_MAX_V = DIM_W'(FRAME_H_MAX);

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH_A  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT_A = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH_B  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT_B = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_COLORKEY_A     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_COLORKEY_B     = 3'd5;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD_A = 2'd0,
    OP_LOAD_B = 2'd1,
    OP_QUERY  = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD_RD,
    ST_LOAD_WR,
    ST_SETUP,
    ST_BOUNDS,
    ST_SCAN,
    ST_DONE
  } state_t;

  typedef logic [SHEET_W-1:0] row_t;

  typedef struct packed {
    logic [DIM_W-1:0] fw_a;
    logic [DIM_W-1:0] fh_a;
    logic [DIM_W-1:0] fw_b;
    logic [DIM_W-1:0] fh_b;
    logic [KEY_W-1:0] key_a;
    logic [KEY_W-1:0] key_b;
  } cfg_t;

  typedef struct packed {
    logic             rd_en;
    logic [ROW_W-1:0] rd_addr_a;
    logic [ROW_W-1:0] rd_addr_b;
    logic             wr_en_a;
    logic             wr_en_b;
    logic [ROW_W-1:0] wr_addr;
    row_t             wr_data;
  } mem_ctl_t;

  typedef struct packed {
    logic [SHIFT_W-1:0] sh_a;
    logic [SHIFT_W-1:0] sh_b;
    logic [DIM_W-1:0]   len;
  } scan_t;

  function automatic logic [DIM_W-1:0] clamp_size(input logic [DIM_W-1:0] v,
                                                  input logic [DIM_W-1:0] max_v);
    logic [DIM_W-1:0] r;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (v > max_v) begin
      r = max_v;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

[design/spc_in_if.sv]
// input item channel: pixel loads and collision queries
interface spc_in_if;
  logic                                 valid;
  logic                                 ready;
  logic [spc_pkg::OP_W-1:0]             op;
  logic [spc_pkg::SX_W-1:0]             sheet_x;
  logic [spc_pkg::SY_W-1:0]             sheet_y;
  logic [spc_pkg::KEY_W-1:0]            pixel_value;
  logic signed [spc_pkg::POS_W-1:0]     pos_a_x;
  logic signed [spc_pkg::POS_W-1:0]     pos_a_y;
  logic [spc_pkg::FRM_W-1:0]            frame_a;
  logic signed [spc_pkg::POS_W-1:0]     pos_b_x;
  logic signed [spc_pkg::POS_W-1:0]     pos_b_y;
  logic [spc_pkg::FRM_W-1:0]            frame_b;

  modport source (output valid, op, sheet_x, sheet_y, pixel_value, pos_a_x, pos_a_y,
                  frame_a, pos_b_x, pos_b_y, frame_b, input ready);
  modport sink (input valid, op, sheet_x, sheet_y, pixel_value, pos_a_x, pos_a_y,
                frame_a, pos_b_x, pos_b_y, frame_b, output ready);
endinterface

[design/spc_out_if.sv]
// result item channel: hit and bounding box overlap flags
interface spc_out_if;
  logic valid;
  logic ready;
  logic hit;
  logic boxes_overlap;

  modport source (output valid, hit, boxes_overlap, input ready);
  modport sink (input valid, hit, boxes_overlap, output ready);
endinterface

[design/spc_ram.sv]
// generic simple dual port ram with registered read
module spc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[design/spc_row_unit.sv]
// shared row unit: aligns both frame windows of one row and tests for a common opaque pixel
module spc_row_unit (
  input  spc_pkg::row_t  row_a,
  input  spc_pkg::row_t  row_b,
  input  spc_pkg::scan_t scan,
  output logic           row_hit
);

  logic [spc_pkg::FRAME_W_MAX-1:0] win_a;
  logic [spc_pkg::FRAME_W_MAX-1:0] win_b;
  logic [spc_pkg::FRAME_W_MAX-1:0] len_mask;

  assign win_a = spc_pkg::FRAME_W_MAX'(row_a >> scan.sh_a);
  assign win_b = spc_pkg::FRAME_W_MAX'(row_b >> scan.sh_b);

  always_comb begin
    for (int i = 0; i < spc_pkg::FRAME_W_MAX; i++) begin
      len_mask[i] = (spc_pkg::DIM_W'(i) < scan.len);
    end
  end

  assign row_hit = |(win_a & win_b & len_mask);

endmodule

[design/spc_ctrl.sv]
// sequencer: pixel load read-modify-write, query bounds and row by row overlap scan
module spc_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  spc_pkg::cfg_t       cfg,
  spc_in_if.sink              in_ch,
  spc_out_if.source           out_ch,
  input  spc_pkg::row_t       rd_row_a,
  input  spc_pkg::row_t       rd_row_b,
  input  logic                row_hit,
  output spc_pkg::mem_ctl_t   mem_ctl,
  output spc_pkg::scan_t      scan
);

  spc_pkg::state_t state_r, state_nxt;

  logic                                accept;
  logic                                ld_in_range;
  logic                                is_b_r;
  logic                                ld_bit_r;
  logic [spc_pkg::COL_W-1:0]           ld_col_r;
  logic [spc_pkg::ROW_W-1:0]           ld_row_r;
  logic signed [spc_pkg::POS_W-1:0]    ax_r, ay_r, bx_r, by_r;
  logic [spc_pkg::FRM_W-1:0]           fa_r, fb_r;
  logic signed [spc_pkg::CRD_W-1:0]    x0_r, x1_r, y0_r, y1_r;
  logic [spc_pkg::SHIFT_W-1:0]         prod_a_r, prod_b_r;
  logic                                ovl_r;
  logic [spc_pkg::DIM_W-1:0]           len_r, nrows_r;
  logic [spc_pkg::ROW_W-1:0]           row_a_r, row_b_r;
  logic [spc_pkg::SHIFT_W-1:0]         sh_a_r, sh_b_r;
  logic [spc_pkg::DIM_W-1:0]           rd_cnt_r;
  logic                                chk_vld_r, chk_last_r, hit_r;
  logic                                out_vld_r, out_hit_r, out_ovl_r;

  logic [spc_pkg::DIM_W-1:0]           wa, ha, wb, hb;
  logic signed [spc_pkg::CRD_W-1:0]    ax_e, ay_e, bx_e, by_e;
  logic signed [spc_pkg::CRD_W-1:0]    ax_end, ay_end, bx_end, by_end;
  logic signed [spc_pkg::CRD_W-1:0]    dx_a, dx_b, dy_a, dy_b, span_x, span_y;
  logic                                ovl_c;
  logic                                issue;
  logic                                scan_stop;
  logic                                out_load;
  spc_pkg::row_t                       ld_row_data;

  assign accept      = in_ch.valid && in_ch.ready;
  assign ld_in_range = (int'(in_ch.sheet_x) < spc_pkg::SHEET_W) &&
                       (int'(in_ch.sheet_y) < spc_pkg::SHEET_H);

  // query bounds
  assign wa = spc_pkg::clamp_size(cfg.fw_a, spc_pkg::FW_MAX_V);
  assign ha = spc_pkg::clamp_size(cfg.fh_a, spc_pkg::FH_MAX_V);
  assign wb = spc_pkg::clamp_size(cfg.fw_b, spc_pkg::FW_MAX_V);
  assign hb = spc_pkg::clamp_size(cfg.fh_b, spc_pkg::FH_MAX_V);

  assign ax_e = spc_pkg::CRD_W'(ax_r);
  assign ay_e = spc_pkg::CRD_W'(ay_r);
  assign bx_e = spc_pkg::CRD_W'(bx_r);
  assign by_e = spc_pkg::CRD_W'(by_r);

  assign ax_end = ax_e + $signed({{(spc_pkg::CRD_W-spc_pkg::DIM_W){1'b0}}, wa});
  assign ay_end = ay_e + $signed({{(spc_pkg::CRD_W-spc_pkg::DIM_W){1'b0}}, ha});
  assign bx_end = bx_e + $signed({{(spc_pkg::CRD_W-spc_pkg::DIM_W){1'b0}}, wb});
  assign by_end = by_e + $signed({{(spc_pkg::CRD_W-spc_pkg::DIM_W){1'b0}}, hb});

  assign ovl_c  = (x0_r < x1_r) && (y0_r < y1_r);
  assign dx_a   = x0_r - ax_e;
  assign dx_b   = x0_r - bx_e;
  assign dy_a   = y0_r - ay_e;
  assign dy_b   = y0_r - by_e;
  assign span_x = x1_r - x0_r;
  assign span_y = y1_r - y0_r;

  assign issue     = (rd_cnt_r != nrows_r);
  assign scan_stop = chk_vld_r && (row_hit || chk_last_r);
  assign out_load  = (state_r == spc_pkg::ST_DONE) && (!out_vld_r || out_ch.ready);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      spc_pkg::ST_IDLE: begin
        if (accept) begin
          case (in_ch.op)
            spc_pkg::OP_LOAD_A,
            spc_pkg::OP_LOAD_B: state_nxt = ld_in_range ? spc_pkg::ST_LOAD_RD
                                                        : spc_pkg::ST_IDLE;
            spc_pkg::OP_QUERY:  state_nxt = spc_pkg::ST_SETUP;
            default:            state_nxt = spc_pkg::ST_IDLE;
          endcase
        end
      end
      spc_pkg::ST_LOAD_RD: state_nxt = spc_pkg::ST_LOAD_WR;
      spc_pkg::ST_LOAD_WR: state_nxt = spc_pkg::ST_IDLE;
      spc_pkg::ST_SETUP:   state_nxt = spc_pkg::ST_BOUNDS;
      spc_pkg::ST_BOUNDS:  state_nxt = ovl_c ? spc_pkg::ST_SCAN : spc_pkg::ST_DONE;
      spc_pkg::ST_SCAN: begin
        if (scan_stop) begin
          state_nxt = spc_pkg::ST_DONE;
        end
      end
      spc_pkg::ST_DONE: begin
        if (out_load) begin
          state_nxt = spc_pkg::ST_IDLE;
        end
      end
      default: state_nxt = spc_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    ld_row_data = is_b_r ? rd_row_b : rd_row_a;
    ld_row_data[ld_col_r] = ld_bit_r;

    in_ch.ready       = (state_r == spc_pkg::ST_IDLE);
    mem_ctl.rd_en     = 1'b0;
    mem_ctl.rd_addr_a = row_a_r + rd_cnt_r[spc_pkg::ROW_W-1:0];
    mem_ctl.rd_addr_b = row_b_r + rd_cnt_r[spc_pkg::ROW_W-1:0];
    mem_ctl.wr_en_a   = 1'b0;
    mem_ctl.wr_en_b   = 1'b0;
    mem_ctl.wr_addr   = ld_row_r;
    mem_ctl.wr_data   = ld_row_data;
    case (state_r)
      spc_pkg::ST_LOAD_RD: begin
        mem_ctl.rd_en     = 1'b1;
        mem_ctl.rd_addr_a = ld_row_r;
        mem_ctl.rd_addr_b = ld_row_r;
      end
      spc_pkg::ST_LOAD_WR: begin
        mem_ctl.wr_en_a = !is_b_r;
        mem_ctl.wr_en_b = is_b_r;
      end
      spc_pkg::ST_SCAN: begin
        mem_ctl.rd_en = issue;
      end
      default: begin
      end
    endcase
  end

  assign scan.sh_a = sh_a_r;
  assign scan.sh_b = sh_b_r;
  assign scan.len  = len_r;

  assign out_ch.valid         = out_vld_r;
  assign out_ch.hit           = out_hit_r;
  assign out_ch.boxes_overlap = out_ovl_r;

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= spc_pkg::ST_IDLE;
      chk_vld_r <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      chk_vld_r <= (state_r == spc_pkg::ST_SCAN) && issue;
      if (out_load) begin
        out_vld_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (accept) begin
      is_b_r   <= (in_ch.op == spc_pkg::OP_LOAD_B);
      ld_bit_r <= (in_ch.op == spc_pkg::OP_LOAD_B) ? (in_ch.pixel_value != cfg.key_b)
                                                   : (in_ch.pixel_value != cfg.key_a);
      ld_col_r <= in_ch.sheet_x[spc_pkg::COL_W-1:0];
      ld_row_r <= in_ch.sheet_y[spc_pkg::ROW_W-1:0];
      ax_r     <= in_ch.pos_a_x;
      ay_r     <= in_ch.pos_a_y;
      bx_r     <= in_ch.pos_b_x;
      by_r     <= in_ch.pos_b_y;
      fa_r     <= in_ch.frame_a;
      fb_r     <= in_ch.frame_b;
    end

    if (state_r == spc_pkg::ST_SETUP) begin
      x0_r     <= (ax_e > bx_e) ? ax_e : bx_e;
      x1_r     <= (ax_end < bx_end) ? ax_end : bx_end;
      y0_r     <= (ay_e > by_e) ? ay_e : by_e;
      y1_r     <= (ay_end < by_end) ? ay_end : by_end;
      prod_a_r <= spc_pkg::SHIFT_W'(fa_r) * spc_pkg::SHIFT_W'(wa);
      prod_b_r <= spc_pkg::SHIFT_W'(fb_r) * spc_pkg::SHIFT_W'(wb);
    end

    if (state_r == spc_pkg::ST_BOUNDS) begin
      ovl_r    <= ovl_c;
      hit_r    <= 1'b0;
      rd_cnt_r <= '0;
      len_r    <= span_x[spc_pkg::DIM_W-1:0];
      nrows_r  <= span_y[spc_pkg::DIM_W-1:0];
      row_a_r  <= dy_a[spc_pkg::ROW_W-1:0];
      row_b_r  <= dy_b[spc_pkg::ROW_W-1:0];
      sh_a_r   <= prod_a_r + spc_pkg::SHIFT_W'(dx_a[spc_pkg::OFFX_W-1:0]);
      sh_b_r   <= prod_b_r + spc_pkg::SHIFT_W'(dx_b[spc_pkg::OFFX_W-1:0]);
    end

    if (state_r == spc_pkg::ST_SCAN) begin
      if (issue) begin
        rd_cnt_r <= rd_cnt_r + 1'b1;
      end
      chk_last_r <= ((rd_cnt_r + 1'b1) == nrows_r);
      if (chk_vld_r && row_hit) begin
        hit_r <= 1'b1;
      end
    end

    if (out_load) begin
      out_hit_r <= hit_r;
      out_ovl_r <= ovl_r;
    end
  end

endmodule

[design/sprite_pixel_collision.sv]
// top level: pixel exact collision test between two animated sprites
//
// in_ch carries one item per handshake: a pixel load for sprite A or B, or a
// collision query. out_ch returns one item per query and none for a load.
// cfg_we/cfg_index/cfg_wdata write the frame sizes and color keys; the user must see
// that writes are made while the block is idle; the block itself does not enforce it.
// Each sprite sheet is a 64 row memory of 256 bit rows. A pixel load is a
// read-modify-write of one row: after the item the block is busy in a read
// state and then a write state. A query first computes the bounding boxes in a
// setup state and a bounds state, then reads one row of each sheet per cycle
// and tests it in the shared row unit, stopping at the first row with a common
// opaque pixel; a query whose boxes do not overlap skips the row scan.
// The block takes no new item until the current one is done; a finished
// result sits in the output register, so a stalled receiver holds back the
// next query's completion and with it every later item.
// Reset clears the sequencer and sets frame sizes to 64 and color keys to 0.
// The sheets are not cleared: pixels must be loaded before they are queried.
module sprite_pixel_collision (
  input  logic                                clk,
  input  logic                                rst_n,
  spc_in_if.sink                              in_ch,
  spc_out_if.source                           out_ch,
  input  logic                                cfg_we,
  input  logic [spc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [spc_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

  spc_pkg::cfg_t     cfg_r;
  spc_pkg::mem_ctl_t mem_ctl;
  spc_pkg::scan_t    scan;
  spc_pkg::row_t     rd_row_a;
  spc_pkg::row_t     rd_row_b;
  logic              row_hit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.fw_a  <= spc_pkg::FW_MAX_V;
      cfg_r.fh_a  <= spc_pkg::FH_MAX_V;
      cfg_r.fw_b  <= spc_pkg::FW_MAX_V;
      cfg_r.fh_b  <= spc_pkg::FH_MAX_V;
      cfg_r.key_a <= '0;
      cfg_r.key_b <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        spc_pkg::CFG_FRAME_WIDTH_A:  cfg_r.fw_a  <= cfg_wdata[spc_pkg::DIM_W-1:0];
        spc_pkg::CFG_FRAME_HEIGHT_A: cfg_r.fh_a  <= cfg_wdata[spc_pkg::DIM_W-1:0];
        spc_pkg::CFG_FRAME_WIDTH_B:  cfg_r.fw_b  <= cfg_wdata[spc_pkg::DIM_W-1:0];
        spc_pkg::CFG_FRAME_HEIGHT_B: cfg_r.fh_b  <= cfg_wdata[spc_pkg::DIM_W-1:0];
        spc_pkg::CFG_COLORKEY_A:     cfg_r.key_a <= cfg_wdata[spc_pkg::KEY_W-1:0];
        spc_pkg::CFG_COLORKEY_B:     cfg_r.key_b <= cfg_wdata[spc_pkg::KEY_W-1:0];
        default: begin
        end
      endcase
    end
  end

  spc_ram #(
    .WIDTH (spc_pkg::SHEET_W),
    .DEPTH (spc_pkg::SHEET_H)
  ) u_mask_a (
    .clk     (clk),
    .wr_en   (mem_ctl.wr_en_a),
    .wr_addr (mem_ctl.wr_addr),
    .wr_data (mem_ctl.wr_data),
    .rd_en   (mem_ctl.rd_en),
    .rd_addr (mem_ctl.rd_addr_a),
    .rd_data (rd_row_a)
  );

  spc_ram #(
    .WIDTH (spc_pkg::SHEET_W),
    .DEPTH (spc_pkg::SHEET_H)
  ) u_mask_b (
    .clk     (clk),
    .wr_en   (mem_ctl.wr_en_b),
    .wr_addr (mem_ctl.wr_addr),
    .wr_data (mem_ctl.wr_data),
    .rd_en   (mem_ctl.rd_en),
    .rd_addr (mem_ctl.rd_addr_b),
    .rd_data (rd_row_b)
  );

  spc_row_unit u_row_unit (
    .row_a   (rd_row_a),
    .row_b   (rd_row_b),
    .scan    (scan),
    .row_hit (row_hit)
  );

  spc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .rd_row_a (rd_row_a),
    .rd_row_b (rd_row_b),
    .row_hit  (row_hit),
    .mem_ctl  (mem_ctl),
    .scan     (scan)
  );

  a_one_sheet_write: assert property (@(posedge clk) disable iff (!rst_n)
    !(mem_ctl.wr_en_a && mem_ctl.wr_en_b))
    else $error("both sheets written in one cycle");

  a_busy_on_write: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_ctl.wr_en_a || mem_ctl.wr_en_b) |-> !in_ch.ready)
    else $error("item taken while a sheet row is written");

  a_query_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready && in_ch.op == spc_pkg::OP_QUERY) |=> !$rose(out_ch.valid))
    else $error("query result raised too early");

  a_hit_needs_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> !(out_ch.hit && !out_ch.boxes_overlap))
    else $error("hit reported without box overlap");

endmodule

[dv/sprite_pixel_collision_tb.sv]
// testbench for sprite_pixel_collision: predicted hit and overlap flags compared per query
module sprite_pixel_collision_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SHEET_CELLS   = spc_pkg::SHEET_W * spc_pkg::SHEET_H;
  localparam int PRELOAD_ITEMS = 2 * SHEET_CELLS;
  localparam int HOLD_AT       = PRELOAD_ITEMS + 100;
  localparam int HOLD_CYCLES   = 400;
  localparam int SETTLE        = 8;
  localparam int DRAIN_CYCLES  = 80;
  localparam int LIMIT         = 1_200_000;
  localparam int MAX_PRINTS    = 100;

  localparam logic [spc_pkg::OP_W-1:0]      OP_RESERVED = 2'd3;
  localparam logic [spc_pkg::CFG_IDX_W-1:0] CFG_SPARE_6 = 3'd6;
  localparam logic [spc_pkg::CFG_IDX_W-1:0] CFG_SPARE_7 = 3'd7;

  typedef struct {
    logic [spc_pkg::OP_W-1:0]         op;
    logic [spc_pkg::SX_W-1:0]         sheet_x;
    logic [spc_pkg::SY_W-1:0]         sheet_y;
    logic [spc_pkg::KEY_W-1:0]        pixel_value;
    logic signed [spc_pkg::POS_W-1:0] pos_a_x;
    logic signed [spc_pkg::POS_W-1:0] pos_a_y;
    logic [spc_pkg::FRM_W-1:0]        frame_a;
    logic signed [spc_pkg::POS_W-1:0] pos_b_x;
    logic signed [spc_pkg::POS_W-1:0] pos_b_y;
    logic [spc_pkg::FRM_W-1:0]        frame_b;
  } sprite_item_t;

  typedef struct {
    bit hit;
    bit boxes_overlap;
  } collision_t;

  logic                           clk;
  logic                           rst_n;
  logic                           cfg_we;
  logic [spc_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [spc_pkg::CFG_DATA_W-1:0] cfg_wdata;

  spc_in_if  in_ch();
  spc_out_if out_ch();

  sprite_pixel_collision u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // predictor state
  bit                        opaque_a [SHEET_CELLS];
  bit                        opaque_b [SHEET_CELLS];
  logic [spc_pkg::DIM_W-1:0] frame_w_a, frame_h_a, frame_w_b, frame_h_b;
  logic [spc_pkg::KEY_W-1:0] ckey_a, ckey_b;

  sprite_item_t pending [$];
  collision_t   collision_q [$];
  sprite_item_t tx_item;
  sprite_item_t acc_item;
  collision_t   want;

  int  mismatches;
  int  in_accepted;
  int  cycles;
  int  stim_count;
  int  tx_gap;
  int  rx_gap;
  int  hold_left;
  bit  hold_done;
  bit  idle_on;

  // stimulus-side view of the current setting
  int                        st_w_a, st_h_a, st_w_b, st_h_b;
  logic [spc_pkg::KEY_W-1:0] st_key_a, st_key_b;

  initial clk = 1'b0;
  always #1 clk = ~clk;

  task automatic report_mismatch(input string msg);
    if (mismatches < MAX_PRINTS) begin
      $display("mismatch at %0t: %s", $time, msg);
    end
    mismatches++;
  endtask

  function automatic int eff_size(input logic [spc_pkg::DIM_W-1:0] v, input int lim);
    if (v == '0) begin
      return 1;
    end
    if (int'(v) > lim) begin
      return lim;
    end
    return int'(v);
  endfunction

  function automatic bit opaque_at(input bit sprite_b, input int col, input int row);
    if (col < 0 || col >= spc_pkg::SHEET_W || row < 0 || row >= spc_pkg::SHEET_H) begin
      return 1'b0;
    end
    return sprite_b ? opaque_b[row * spc_pkg::SHEET_W + col]
                    : opaque_a[row * spc_pkg::SHEET_W + col];
  endfunction

  function automatic collision_t predict_collision(input sprite_item_t q);
    collision_t r;
    int ax, ay, bx, by, fa, fb, wa, ha, wb, hb;
    int x0, x1, y0, y1, x, y;
    ax = q.pos_a_x;
    ay = q.pos_a_y;
    bx = q.pos_b_x;
    by = q.pos_b_y;
    fa = q.frame_a;
    fb = q.frame_b;
    wa = eff_size(frame_w_a, spc_pkg::FRAME_W_MAX);
    ha = eff_size(frame_h_a, spc_pkg::FRAME_H_MAX);
    wb = eff_size(frame_w_b, spc_pkg::FRAME_W_MAX);
    hb = eff_size(frame_h_b, spc_pkg::FRAME_H_MAX);
    x0 = (ax > bx) ? ax : bx;
    y0 = (ay > by) ? ay : by;
    x1 = (ax + wa < bx + wb) ? ax + wa : bx + wb;
    y1 = (ay + ha < by + hb) ? ay + ha : by + hb;
    r.boxes_overlap = (x0 < x1) && (y0 < y1);
    r.hit = 1'b0;
    if (r.boxes_overlap) begin
      for (y = y0; y < y1 && !r.hit; y++) begin
        for (x = x0; x < x1 && !r.hit; x++) begin
          if (opaque_at(1'b0, fa * wa + x - ax, y - ay) &&
              opaque_at(1'b1, fb * wb + x - bx, y - by)) begin
            r.hit = 1'b1;
          end
        end
      end
    end
    return r;
  endfunction

  // sender
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      tx_gap <= 0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (tx_gap != 0) begin
        in_ch.valid <= 1'b0;
        tx_gap <= tx_gap - 1;
      end else if (pending.size() != 0) begin
        tx_item = pending.pop_front();
        in_ch.op          <= tx_item.op;
        in_ch.sheet_x     <= tx_item.sheet_x;
        in_ch.sheet_y     <= tx_item.sheet_y;
        in_ch.pixel_value <= tx_item.pixel_value;
        in_ch.pos_a_x     <= tx_item.pos_a_x;
        in_ch.pos_a_y     <= tx_item.pos_a_y;
        in_ch.frame_a     <= tx_item.frame_a;
        in_ch.pos_b_x     <= tx_item.pos_b_x;
        in_ch.pos_b_y     <= tx_item.pos_b_y;
        in_ch.frame_b     <= tx_item.frame_b;
        in_ch.valid       <= 1'b1;
        if (idle_on && $urandom_range(0, 9) == 0) begin
          tx_gap <= $urandom_range(1, 17);
        end
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // long receiver hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (!hold_done && in_accepted >= HOLD_AT) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end
  end

  // receiver
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      rx_gap <= 0;
    end else if (hold_left != 0) begin
      out_ch.ready <= 1'b0;
    end else if (rx_gap != 0) begin
      out_ch.ready <= 1'b0;
      rx_gap <= rx_gap - 1;
    end else if (idle_on && $urandom_range(0, 9) == 0) begin
      out_ch.ready <= 1'b0;
      rx_gap <= $urandom_range(0, 16);
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // register writes, result check and prediction
  always @(posedge clk) begin
    if (!rst_n) begin
      frame_w_a = spc_pkg::DIM_W'(64);
      frame_h_a = spc_pkg::DIM_W'(64);
      frame_w_b = spc_pkg::DIM_W'(64);
      frame_h_b = spc_pkg::DIM_W'(64);
      ckey_a = '0;
      ckey_b = '0;
      in_accepted <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          spc_pkg::CFG_FRAME_WIDTH_A:  frame_w_a = cfg_wdata[spc_pkg::DIM_W-1:0];
          spc_pkg::CFG_FRAME_HEIGHT_A: frame_h_a = cfg_wdata[spc_pkg::DIM_W-1:0];
          spc_pkg::CFG_FRAME_WIDTH_B:  frame_w_b = cfg_wdata[spc_pkg::DIM_W-1:0];
          spc_pkg::CFG_FRAME_HEIGHT_B: frame_h_b = cfg_wdata[spc_pkg::DIM_W-1:0];
          spc_pkg::CFG_COLORKEY_A:     ckey_a = cfg_wdata[spc_pkg::KEY_W-1:0];
          spc_pkg::CFG_COLORKEY_B:     ckey_b = cfg_wdata[spc_pkg::KEY_W-1:0];
          default: ;
        endcase
      end
      if (out_ch.valid && out_ch.ready) begin
        if (collision_q.size() == 0) begin
          report_mismatch("result item with no query waiting");
        end else begin
          want = collision_q.pop_front();
          if (out_ch.hit !== want.hit) begin
            report_mismatch($sformatf("hit got %b want %b", out_ch.hit, want.hit));
          end
          if (out_ch.boxes_overlap !== want.boxes_overlap) begin
            report_mismatch($sformatf("boxes_overlap got %b want %b",
                                      out_ch.boxes_overlap, want.boxes_overlap));
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        acc_item.op          = in_ch.op;
        acc_item.sheet_x     = in_ch.sheet_x;
        acc_item.sheet_y     = in_ch.sheet_y;
        acc_item.pixel_value = in_ch.pixel_value;
        acc_item.pos_a_x     = in_ch.pos_a_x;
        acc_item.pos_a_y     = in_ch.pos_a_y;
        acc_item.frame_a     = in_ch.frame_a;
        acc_item.pos_b_x     = in_ch.pos_b_x;
        acc_item.pos_b_y     = in_ch.pos_b_y;
        acc_item.frame_b     = in_ch.frame_b;
        in_accepted <= in_accepted + 1;
        case (acc_item.op)
          spc_pkg::OP_LOAD_A:
            opaque_a[acc_item.sheet_y * spc_pkg::SHEET_W + acc_item.sheet_x] =
              (acc_item.pixel_value != ckey_a);
          spc_pkg::OP_LOAD_B:
            opaque_b[acc_item.sheet_y * spc_pkg::SHEET_W + acc_item.sheet_x] =
              (acc_item.pixel_value != ckey_b);
          spc_pkg::OP_QUERY:  collision_q.push_back(predict_collision(acc_item));
          default: ;
        endcase
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic sprite_item_t noise_item();
    sprite_item_t it;
    it.op          = OP_RESERVED;
    it.sheet_x     = spc_pkg::SX_W'($urandom());
    it.sheet_y     = spc_pkg::SY_W'($urandom());
    it.pixel_value = $urandom();
    it.pos_a_x     = spc_pkg::POS_W'($urandom());
    it.pos_a_y     = spc_pkg::POS_W'($urandom());
    it.frame_a     = spc_pkg::FRM_W'($urandom());
    it.pos_b_x     = spc_pkg::POS_W'($urandom());
    it.pos_b_y     = spc_pkg::POS_W'($urandom());
    it.frame_b     = spc_pkg::FRM_W'($urandom());
    return it;
  endfunction

  function automatic logic [spc_pkg::KEY_W-1:0] opaque_pixel(
      input logic [spc_pkg::KEY_W-1:0] key);
    logic [spc_pkg::KEY_W-1:0] v;
    v = $urandom();
    if (v == key) begin
      v = ~key;
    end
    return v;
  endfunction

  function automatic logic [spc_pkg::KEY_W-1:0] pick_pixel(
      input logic [spc_pkg::KEY_W-1:0] key);
    return $urandom_range(0, 1) ? key : opaque_pixel(key);
  endfunction

  function automatic logic [spc_pkg::CFG_DATA_W-1:0] size_word(input int v);
    logic [spc_pkg::CFG_DATA_W-1:0] w;
    w = $urandom();
    w[spc_pkg::DIM_W-1:0] = spc_pkg::DIM_W'(v);
    return w;
  endfunction

  task automatic push_load(input logic [spc_pkg::OP_W-1:0] op, input int x, input int y,
                           input logic [spc_pkg::KEY_W-1:0] v);
    sprite_item_t it;
    it = noise_item();
    it.op          = op;
    it.sheet_x     = spc_pkg::SX_W'(x);
    it.sheet_y     = spc_pkg::SY_W'(y);
    it.pixel_value = v;
    pending.push_back(it);
    stim_count++;
  endtask

  task automatic push_query(input int ax, input int ay, input int fa,
                            input int bx, input int by, input int fb);
    sprite_item_t it;
    it = noise_item();
    it.op      = spc_pkg::OP_QUERY;
    it.pos_a_x = spc_pkg::POS_W'(ax);
    it.pos_a_y = spc_pkg::POS_W'(ay);
    it.frame_a = spc_pkg::FRM_W'(fa);
    it.pos_b_x = spc_pkg::POS_W'(bx);
    it.pos_b_y = spc_pkg::POS_W'(by);
    it.frame_b = spc_pkg::FRM_W'(fb);
    pending.push_back(it);
    stim_count++;
  endtask

  task automatic set_reg(input logic [spc_pkg::CFG_IDX_W-1:0] idx,
                         input logic [spc_pkg::CFG_DATA_W-1:0] d);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= d;
  endtask

  task automatic apply_setting(input int wa, input int ha, input int wb, input int hb,
                               input logic [spc_pkg::KEY_W-1:0] ka,
                               input logic [spc_pkg::KEY_W-1:0] kb,
                               input bit spare);
    set_reg(spc_pkg::CFG_FRAME_WIDTH_A, size_word(wa));
    set_reg(spc_pkg::CFG_FRAME_HEIGHT_A, size_word(ha));
    set_reg(spc_pkg::CFG_FRAME_WIDTH_B, size_word(wb));
    set_reg(spc_pkg::CFG_FRAME_HEIGHT_B, size_word(hb));
    set_reg(spc_pkg::CFG_COLORKEY_A, ka);
    set_reg(spc_pkg::CFG_COLORKEY_B, kb);
    if (spare) begin
      set_reg(CFG_SPARE_6, $urandom());
      set_reg(CFG_SPARE_7, $urandom());
    end
    @(posedge clk);
    cfg_we <= 1'b0;
    st_w_a = eff_size(spc_pkg::DIM_W'(wa), spc_pkg::FRAME_W_MAX);
    st_h_a = eff_size(spc_pkg::DIM_W'(ha), spc_pkg::FRAME_H_MAX);
    st_w_b = eff_size(spc_pkg::DIM_W'(wb), spc_pkg::FRAME_W_MAX);
    st_h_b = eff_size(spc_pkg::DIM_W'(hb), spc_pkg::FRAME_H_MAX);
    st_key_a = ka;
    st_key_b = kb;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    while (pending.size() != 0 || in_ch.valid || collision_q.size() != 0) begin
      @(negedge clk);
    end
    repeat (SETTLE) @(negedge clk);
  endtask

  // sparse opaque pixels everywhere so every query reads written bits
  task automatic preload_sheets();
    int x, y;
    for (y = 0; y < spc_pkg::SHEET_H; y++) begin
      for (x = 0; x < spc_pkg::SHEET_W; x++) begin
        push_load(spc_pkg::OP_LOAD_A, x, y,
                  ($urandom_range(0, 63) == 0) ? opaque_pixel(st_key_a) : st_key_a);
        push_load(spc_pkg::OP_LOAD_B, x, y,
                  ($urandom_range(0, 63) == 0) ? opaque_pixel(st_key_b) : st_key_b);
      end
    end
  endtask

  // expects 64x64 frames, key A all zeros, key B all ones
  task automatic directed_items();
    sprite_item_t it;
    push_load(spc_pkg::OP_LOAD_A, 255, 63, 32'hFFFF_FFFF);
    push_load(spc_pkg::OP_LOAD_B, 255, 63, 32'h0000_0000);
    push_load(spc_pkg::OP_LOAD_A, 0, 0, 32'h0000_0000);
    push_load(spc_pkg::OP_LOAD_B, 0, 0, 32'hFFFF_FFFF);
    push_load(spc_pkg::OP_LOAD_A, 64, 0, 32'h0000_0001);
    push_load(spc_pkg::OP_LOAD_B, 128, 0, 32'hFFFF_FFFE);
    it = noise_item();
    pending.push_back(it);
    push_query(0, 0, 3, 0, 0, 3);
    push_query(0, 0, 0, 64, 0, 0);
    push_query(0, 0, 0, 0, 64, 0);
    push_query(0, 0, 0, -64, 0, 0);
    push_query(0, 0, 0, 0, -64, 0);
    push_query(63, 63, 3, 0, 0, 0);
    push_query(-2048, -2048, 0, 2047, 2047, 3);
    push_query(2047, 2047, 3, 2047, 2047, 3);
    push_query(-2048, -2048, 1, -2048, -2048, 2);
    push_query(2047, -2048, 2, -2048, 2047, 1);
    push_query(1985, 100, 0, 2047, 120, 1);
  endtask

  // opaque pixels of both sprites placed on the same screen spot, A's sometimes cleared again, then queried
  task automatic aligned_sequence();
    int fa, fb, ca, ra, cb, rb, ax, ay;
    fa = $urandom_range(0, 3);
    fb = $urandom_range(0, 3);
    ca = $urandom_range(0, st_w_a - 1);
    ra = $urandom_range(0, st_h_a - 1);
    cb = $urandom_range(0, st_w_b - 1);
    rb = $urandom_range(0, st_h_b - 1);
    push_load(spc_pkg::OP_LOAD_A, fa * st_w_a + ca, ra, opaque_pixel(st_key_a));
    push_load(spc_pkg::OP_LOAD_B, fb * st_w_b + cb, rb, opaque_pixel(st_key_b));
    if ($urandom_range(0, 3) == 0) begin
      push_load(spc_pkg::OP_LOAD_A, fa * st_w_a + ca, ra, st_key_a);
    end
    if ($urandom_range(0, 9) == 0) begin
      ax = $signed(spc_pkg::POS_W'($urandom()));
      ay = $signed(spc_pkg::POS_W'($urandom()));
    end else begin
      ax = $urandom_range(0, 400) - 200;
      ay = $urandom_range(0, 400) - 200;
    end
    push_query(ax, ay, fa, ax + ca - cb, ay + ra - rb, fb);
  endtask

  task automatic random_query();
    int ax, ay, bx, by;
    if ($urandom_range(0, 4) == 0) begin
      ax = $signed(spc_pkg::POS_W'($urandom()));
      ay = $signed(spc_pkg::POS_W'($urandom()));
    end else begin
      ax = $urandom_range(0, 300) - 150;
      ay = $urandom_range(0, 300) - 150;
    end
    if ($urandom_range(0, 9) < 7) begin
      bx = ax + $urandom_range(0, 160) - 80;
      by = ay + $urandom_range(0, 160) - 80;
    end else begin
      bx = $signed(spc_pkg::POS_W'($urandom()));
      by = $signed(spc_pkg::POS_W'($urandom()));
    end
    push_query(ax, ay, $urandom_range(0, 3), bx, by, $urandom_range(0, 3));
  endtask

  task automatic gen_random_items(input int n);
    int stop_at, sel;
    sprite_item_t it;
    stop_at = stim_count + n;
    while (stim_count < stop_at) begin
      sel = $urandom_range(0, 99);
      if (sel < 35) begin
        aligned_sequence();
      end else if (sel < 52) begin
        push_load(spc_pkg::OP_LOAD_A, $urandom_range(0, 255), $urandom_range(0, 63),
                  pick_pixel(st_key_a));
      end else if (sel < 69) begin
        push_load(spc_pkg::OP_LOAD_B, $urandom_range(0, 255), $urandom_range(0, 63),
                  pick_pixel(st_key_b));
      end else if (sel < 97) begin
        random_query();
      end else begin
        it = noise_item();
        pending.push_back(it);
      end
    end
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.op = '0;
    in_ch.sheet_x = '0;
    in_ch.sheet_y = '0;
    in_ch.pixel_value = '0;
    in_ch.pos_a_x = '0;
    in_ch.pos_a_y = '0;
    in_ch.frame_a = '0;
    in_ch.pos_b_x = '0;
    in_ch.pos_b_y = '0;
    in_ch.frame_b = '0;
    out_ch.ready = 1'b0;
    idle_on = 1'b0;
    mismatches = 0;
    cycles = 0;
    stim_count = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    apply_setting(64, 64, 64, 64, 32'h0000_0000, 32'hFFFF_FFFF, 1'b0);
    preload_sheets();
    wait_drained();
    idle_on = 1'b1;
    directed_items();
    gen_random_items(170);
    wait_drained();

    apply_setting(1, 1, 1, 1, $urandom(), $urandom(), 1'b0);
    gen_random_items(150);
    wait_drained();

    // out of range sizes and writes past the register list
    apply_setting(0, 127, 127, 0, $urandom(), $urandom(), 1'b1);
    gen_random_items(150);
    wait_drained();

    apply_setting($urandom_range(1, 64), $urandom_range(1, 64), $urandom_range(1, 64),
                  $urandom_range(1, 64), $urandom(), $urandom(), 1'b0);
    gen_random_items(170);
    wait_drained();

    apply_setting($urandom_range(1, 16), $urandom_range(1, 16), $urandom_range(1, 16),
                  $urandom_range(1, 16), 32'hFFFF_FFFF, 32'h0000_0000, 1'b0);
    gen_random_items(150);
    wait_drained();

    idle_on = 1'b0;
    apply_setting($urandom_range(1, 64), $urandom_range(1, 64), $urandom_range(1, 64),
                  $urandom_range(1, 64), $urandom(), $urandom(), 1'b0);
    gen_random_items(160);
    wait_drained();

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (collision_q.size() != 0) begin
      report_mismatch($sformatf("%0d query results never arrived", collision_q.size()));
    end
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
